// File: hw/rtl/bcec_pkg.sv
`timescale 1ns / 1ps
package bcec_pkg;

	localparam int DATA_BITS = 8;
	localparam int CODE_BITS = 16;
	localparam int NUM_ROWS  = 8;
	localparam int REG_W     = 16;
	localparam int IDX_W     = 4;
	localparam int ROW_W     = $clog2(NUM_ROWS);
	localparam int POS_W     = $clog2(CODE_BITS);

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef logic [NUM_ROWS-1:0][REG_W-1:0] h_mat_t;

	typedef struct packed {
		logic valid;
		logic op;
	} ctl_t;

endpackage

// File: hw/rtl/bcec_cfg_regs.sv
`timescale 1ns / 1ps
module bcec_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bcec_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bcec_pkg::REG_W-1:0]   cfg_data,
	output bcec_pkg::h_mat_t             h_mat
);

	bcec_pkg::h_mat_t h_q;

	assign cfg_ready = 1'b1;
	assign h_mat     = h_q;

	// drop writes past the last row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (cfg_valid && cfg_index < bcec_pkg::IDX_W'(bcec_pkg::NUM_ROWS)) begin
			h_q[cfg_index[bcec_pkg::ROW_W-1:0]] <= cfg_data;
		end
	end

endmodule

// File: hw/rtl/bcec_syndrome.sv
`timescale 1ns / 1ps
module bcec_syndrome (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bcec_pkg::h_mat_t                 h_mat,
	input  bcec_pkg::ctl_t                   ctl_s1,
	input  logic [bcec_pkg::CODE_BITS-1:0]   word_s1,
	output bcec_pkg::ctl_t                   ctl_s2,
	output logic [bcec_pkg::CODE_BITS-1:0]   word_s2,
	output logic [bcec_pkg::DATA_BITS-1:0]   syn_s2
);

	logic [bcec_pkg::DATA_BITS-1:0] syn_d;

	// one parity tree per used row
	always_comb begin
		for (int i = 0; i < bcec_pkg::DATA_BITS; i++) begin
			syn_d[i] = ^(h_mat[i][bcec_pkg::CODE_BITS-1:0] & word_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word_s1;
		syn_s2  <= syn_d;
	end

endmodule

// File: hw/rtl/bcec_match.sv
`timescale 1ns / 1ps
module bcec_match (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bcec_pkg::h_mat_t                 h_mat,
	input  bcec_pkg::ctl_t                   ctl_s2,
	input  logic [bcec_pkg::CODE_BITS-1:0]   word_s2,
	input  logic [bcec_pkg::DATA_BITS-1:0]   syn_s2,
	output bcec_pkg::ctl_t                   ctl_s3,
	output logic [bcec_pkg::CODE_BITS-1:0]   word_s3,
	output logic [bcec_pkg::DATA_BITS-1:0]   syn_s3,
	output logic [bcec_pkg::CODE_BITS-1:0]   match_s3,
	output logic                             err_s3
);

	logic [bcec_pkg::CODE_BITS-1:0][bcec_pkg::DATA_BITS-1:0] col;
	logic [bcec_pkg::CODE_BITS-1:0]                          match_d;

	// match_d[j] is set when H column j (first code bit is column 0) equals the syndrome
	always_comb begin
		for (int j = 0; j < bcec_pkg::CODE_BITS; j++) begin
			for (int i = 0; i < bcec_pkg::DATA_BITS; i++) begin
				col[j][i] = h_mat[i][bcec_pkg::CODE_BITS-1-j];
			end
			match_d[j] = (col[j] == syn_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		word_s3  <= word_s2;
		syn_s3   <= syn_s2;
		match_s3 <= match_d;
		err_s3   <= |syn_s2;
	end

endmodule

// File: hw/rtl/bcec_correct.sv
`timescale 1ns / 1ps
module bcec_correct (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bcec_pkg::ctl_t                   ctl_s3,
	input  logic [bcec_pkg::CODE_BITS-1:0]   word_s3,
	input  logic [bcec_pkg::DATA_BITS-1:0]   syn_s3,
	input  logic [bcec_pkg::CODE_BITS-1:0]   match_s3,
	input  logic                             err_s3,
	output logic                             done_s4,
	output logic [bcec_pkg::CODE_BITS-1:0]   word_s4,
	output logic [bcec_pkg::DATA_BITS-1:0]   dout_s4,
	output logic                             err_s4,
	output logic                             corr_s4,
	output logic [bcec_pkg::POS_W-1:0]       pos_s4,
	output logic                             unc_s4
);

	logic                             found;
	logic [bcec_pkg::POS_W-1:0]       first;
	logic [bcec_pkg::DATA_BITS-1:0]   par;
	logic [bcec_pkg::CODE_BITS-1:0]   word_d;
	logic                             err_d;
	logic                             corr_d;
	logic                             unc_d;
	logic [bcec_pkg::POS_W-1:0]       pos_d;

	// lowest matching column wins: scan from the top so the last hit sticks
	always_comb begin
		found = 1'b0;
		first = '0;
		for (int j = bcec_pkg::CODE_BITS - 1; j >= 0; j--) begin
			if (match_s3[j]) begin
				found = 1'b1;
				first = bcec_pkg::POS_W'(j);
			end
		end
	end

	// parity row 0 lands on the top parity bit
	always_comb begin
		for (int i = 0; i < bcec_pkg::DATA_BITS; i++) begin
			par[bcec_pkg::DATA_BITS-1-i] = syn_s3[i];
		end
	end

	always_comb begin
		word_d = word_s3;
		err_d  = 1'b0;
		corr_d = 1'b0;
		unc_d  = 1'b0;
		pos_d  = '0;
		case (ctl_s3.op)
			bcec_pkg::OP_ENCODE: begin
				word_d = {word_s3[bcec_pkg::CODE_BITS-1:bcec_pkg::DATA_BITS], par};
			end
			bcec_pkg::OP_DECODE: begin
				err_d  = err_s3;
				corr_d = err_s3 && found;
				unc_d  = err_s3 && !found;
				if (err_s3 && found) begin
					pos_d  = first;
					word_d = word_s3
						^ (bcec_pkg::CODE_BITS'(1) << (bcec_pkg::POS_W'(bcec_pkg::CODE_BITS - 1) - first));
				end
			end
			default: begin
				word_d = word_s3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		word_s4 <= word_d;
		dout_s4 <= word_d[bcec_pkg::CODE_BITS-1 -: bcec_pkg::DATA_BITS];
		err_s4  <= err_d;
		corr_s4 <= corr_d;
		pos_s4  <= pos_d;
		unc_s4  <= unc_d;
	end

endmodule

// File: hw/rtl/block_code_encode_correct.sv
`timescale 1ns / 1ps
// Pipeline: four register stages (s1, s2, s3, s4) lie between a taken start and done.
// Throughput: one word per cycle; busy stays low, so start may be held every cycle.
// The result sits on the output ports for exactly one cycle with done; it is not held.
// Reset (arst_n low) clears the pipeline valid bits and all H rows to zero.
// Config writes are taken every cycle (cfg_ready high); indexes past row 7 are dropped.
module block_code_encode_correct (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             op,
	input  logic [bcec_pkg::CODE_BITS-1:0]   data_in,
	output logic                             done,
	output logic [bcec_pkg::CODE_BITS-1:0]   result_word,
	output logic [bcec_pkg::DATA_BITS-1:0]   data_out,
	output logic                             error_seen,
	output logic                             corrected,
	output logic [bcec_pkg::POS_W-1:0]       flip_position,
	output logic                             uncorrectable,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bcec_pkg::IDX_W-1:0]       cfg_index,
	input  logic [bcec_pkg::REG_W-1:0]       cfg_data
);

	bcec_pkg::h_mat_t                 h_mat;
	bcec_pkg::ctl_t                   ctl_s1;
	bcec_pkg::ctl_t                   ctl_s2;
	bcec_pkg::ctl_t                   ctl_s3;
	logic [bcec_pkg::CODE_BITS-1:0]   word_in;
	logic [bcec_pkg::CODE_BITS-1:0]   word_s1;
	logic [bcec_pkg::CODE_BITS-1:0]   word_s2;
	logic [bcec_pkg::CODE_BITS-1:0]   word_s3;
	logic [bcec_pkg::DATA_BITS-1:0]   syn_s2;
	logic [bcec_pkg::DATA_BITS-1:0]   syn_s3;
	logic [bcec_pkg::CODE_BITS-1:0]   match_s3;
	logic                             err_s3;

	assign busy = 1'b0;

	// encode runs the syndrome over the data placed in the top code bits
	always_comb begin
		case (op)
			bcec_pkg::OP_ENCODE: begin
				word_in = bcec_pkg::CODE_BITS'({data_in[bcec_pkg::DATA_BITS-1:0],
					{bcec_pkg::DATA_BITS{1'b0}}});
			end
			default: begin
				word_in = data_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start && !busy;
			ctl_s1.op    <= op;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= word_in;
	end

	bcec_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.h_mat     (h_mat)
	);

	bcec_syndrome u_syn (
		.clk     (clk),
		.arst_n  (arst_n),
		.h_mat   (h_mat),
		.ctl_s1  (ctl_s1),
		.word_s1 (word_s1),
		.ctl_s2  (ctl_s2),
		.word_s2 (word_s2),
		.syn_s2  (syn_s2)
	);

	bcec_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.h_mat    (h_mat),
		.ctl_s2   (ctl_s2),
		.word_s2  (word_s2),
		.syn_s2   (syn_s2),
		.ctl_s3   (ctl_s3),
		.word_s3  (word_s3),
		.syn_s3   (syn_s3),
		.match_s3 (match_s3),
		.err_s3   (err_s3)
	);

	bcec_correct u_corr (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s3   (ctl_s3),
		.word_s3  (word_s3),
		.syn_s3   (syn_s3),
		.match_s3 (match_s3),
		.err_s3   (err_s3),
		.done_s4  (done),
		.word_s4  (result_word),
		.dout_s4  (data_out),
		.err_s4   (error_seen),
		.corr_s4  (corrected),
		.pos_s4   (flip_position),
		.unc_s4   (uncorrectable)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted word did not complete in four cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##4 !done)
		else $error("result strobe without an accepted word");

	a_clean_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && !error_seen |-> !corrected && !uncorrectable && flip_position == '0)
		else $error("correction flags set with zero syndrome");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done && error_seen |-> corrected != uncorrectable)
		else $error("nonzero syndrome must be either corrected or uncorrectable");

endmodule

// File: tb/codeword_checker.sv
`timescale 1ns / 1ps
module codeword_checker import bcec_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 op,
	input  logic [CODE_BITS-1:0] data_in,
	input  logic                 done,
	input  logic [CODE_BITS-1:0] result_word,
	input  logic [DATA_BITS-1:0] data_out,
	input  logic                 error_seen,
	input  logic                 corrected,
	input  logic [POS_W-1:0]     flip_position,
	input  logic                 uncorrectable,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output int                   words_in_flight,
	output int                   mismatch_count
);

	typedef struct packed {
		logic [CODE_BITS-1:0] word;
		logic [DATA_BITS-1:0] dout;
		logic                 err;
		logic                 corr;
		logic [POS_W-1:0]     pos;
		logic                 unc;
	} outcome_t;

	logic [REG_W-1:0] h_copy [NUM_ROWS];
	outcome_t         outcome_q [$];

	function automatic outcome_t code_outcome(logic o, logic [CODE_BITS-1:0] din);
		outcome_t             r;
		logic [DATA_BITS-1:0] d;
		logic [DATA_BITS-1:0] par;
		logic [DATA_BITS-1:0] syn;
		logic [DATA_BITS-1:0] col;
		logic [31:0]          wide;
		logic [CODE_BITS-1:0] w;
		logic                 acc;
		logic                 hit;
		r = '0;
		if (o == OP_ENCODE) begin
			d = din[DATA_BITS-1:0];
			par = '0;
			for (int i = 0; i < DATA_BITS; i++) begin
				acc = 1'b0;
				for (int j = 0; j < DATA_BITS; j++)
					acc ^= h_copy[i][CODE_BITS-1-j] & d[DATA_BITS-1-j];
				par[DATA_BITS-1-i] = acc;
			end
			wide = (32'(d) << DATA_BITS) | 32'(par);
			w = wide[CODE_BITS-1:0];
			r.dout = d;
		end else begin
			w = din;
			for (int i = 0; i < DATA_BITS; i++)
				syn[i] = ^(h_copy[i][CODE_BITS-1:0] & w);
			if (syn != '0) begin
				r.err = 1'b1;
				hit = 1'b0;
				// lowest matching column wins
				for (int j = 0; j < CODE_BITS; j++) begin
					if (!hit) begin
						for (int i = 0; i < DATA_BITS; i++)
							col[i] = h_copy[i][CODE_BITS-1-j];
						if (col == syn) begin
							w[CODE_BITS-1-j] = ~w[CODE_BITS-1-j];
							r.corr = 1'b1;
							r.pos = j[POS_W-1:0];
							hit = 1'b1;
						end
					end
				end
				r.unc = !hit;
			end
			r.dout = w[CODE_BITS-1 -: DATA_BITS];
		end
		r.word = w;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		int       bad;
		if (!arst_n) begin
			outcome_q.delete();
			for (int k = 0; k < NUM_ROWS; k++)
				h_copy[k] = '0;
			words_in_flight <= 0;
			mismatch_count <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready && cfg_index < NUM_ROWS)
				h_copy[cfg_index[ROW_W-1:0]] = cfg_data;
			// retire before taking a new word
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result word with nothing outstanding: %h", result_word);
					bad++;
				end else begin
					want = outcome_q.pop_front();
					if (result_word !== want.word) begin
						$error("result_word: expected %h, got %h", want.word, result_word);
						bad++;
					end
					if (data_out !== want.dout) begin
						$error("data_out: expected %h, got %h", want.dout, data_out);
						bad++;
					end
					if (error_seen !== want.err) begin
						$error("error_seen: expected %b, got %b", want.err, error_seen);
						bad++;
					end
					if (corrected !== want.corr) begin
						$error("corrected: expected %b, got %b", want.corr, corrected);
						bad++;
					end
					if (flip_position !== want.pos) begin
						$error("flip_position: expected %0d, got %0d", want.pos, flip_position);
						bad++;
					end
					if (uncorrectable !== want.unc) begin
						$error("uncorrectable: expected %b, got %b", want.unc, uncorrectable);
						bad++;
					end
				end
			end
			if (start && !busy)
				outcome_q.insert(outcome_q.size(), code_outcome(op, data_in));
			words_in_flight <= outcome_q.size();
			mismatch_count <= mismatch_count + bad;
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import bcec_pkg::*;

	localparam int HOLD_DRAIN    = -1;
	localparam int PHASE_COUNT   = 6;
	localparam int PHASE_ITEMS   = 256;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 op = OP_ENCODE;
	logic [CODE_BITS-1:0] data_in = '0;
	logic                 done;
	logic [CODE_BITS-1:0] result_word;
	logic [DATA_BITS-1:0] data_out;
	logic                 error_seen;
	logic                 corrected;
	logic [POS_W-1:0]     flip_position;
	logic                 uncorrectable;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;
	int                   words_in_flight;
	int                   mismatch_count;

	// rows of H as last written
	logic [REG_W-1:0]     h_set [NUM_ROWS];

	always #1 clk = ~clk;

	block_code_encode_correct u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.data_in       (data_in),
		.done          (done),
		.result_word   (result_word),
		.data_out      (data_out),
		.error_seen    (error_seen),
		.corrected     (corrected),
		.flip_position (flip_position),
		.uncorrectable (uncorrectable),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	codeword_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.data_in         (data_in),
		.done            (done),
		.result_word     (result_word),
		.data_out        (data_out),
		.error_seen      (error_seen),
		.corrected       (corrected),
		.flip_position   (flip_position),
		.uncorrectable   (uncorrectable),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.words_in_flight (words_in_flight),
		.mismatch_count  (mismatch_count)
	);

	// valid codeword for a systematic H; just some word otherwise
	function automatic logic [CODE_BITS-1:0] codeword_for(logic [DATA_BITS-1:0] d);
		logic [DATA_BITS-1:0] par;
		for (int i = 0; i < DATA_BITS; i++)
			par[DATA_BITS-1-i] = ^(h_set[i][CODE_BITS-1 -: DATA_BITS] & d);
		return {d, par};
	endfunction

	// H = [P | I], column j of P taken from pcols[DATA_BITS*j +: DATA_BITS]
	task automatic set_systematic(input logic [DATA_BITS*DATA_BITS-1:0] pcols);
		logic [REG_W-1:0] row;
		for (int i = 0; i < DATA_BITS; i++) begin
			row = '0;
			for (int j = 0; j < DATA_BITS; j++)
				row[CODE_BITS-1-j] = pcols[DATA_BITS*j + i];
			row[DATA_BITS-1-i] = 1'b1;
			h_set[i] = row;
		end
	endtask

	task automatic drain();
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
	endtask

	// write every row, then one stray index past the last row
	task automatic write_h();
		for (int i = 0; i <= NUM_ROWS; i++) begin
			cfg_valid <= 1'b1;
			if (i < NUM_ROWS) begin
				cfg_index <= IDX_W'(i);
				cfg_data <= h_set[i];
			end else begin
				cfg_index <= IDX_W'($urandom_range(NUM_ROWS, (1 << IDX_W) - 1));
				cfg_data <= REG_W'($urandom);
			end
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(input logic o, input logic [CODE_BITS-1:0] d, input int hold);
		start <= 1'b1;
		op <= o;
		data_in <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (hold != 0) begin
			start <= 1'b0;
			if (hold == HOLD_DRAIN)
				drain();
			else
				repeat (hold) @(posedge clk);
		end
	endtask

	initial begin
		logic [CODE_BITS-1:0]           cw;
		logic [CODE_BITS-1:0]           rnd;
		logic [DATA_BITS*DATA_BITS-1:0] pcols;
		int                             r;
		int                             g;
		int                             a;
		int                             b;
		int                             hold;
		bit                             burst;

		for (int i = 0; i < NUM_ROWS; i++)
			h_set[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// H still zero from reset
		send_word(OP_ENCODE, 16'hFFFF, 0);
		send_word(OP_DECODE, 16'hFFFF, HOLD_DRAIN);

		// weight-3 columns: single errors correct, double errors do not
		set_systematic({8'h19, 8'h16, 8'h15, 8'h13, 8'h0E, 8'h0D, 8'h0B, 8'h07});
		write_h();
		send_word(OP_ENCODE, 16'h0000, 0);
		send_word(OP_ENCODE, 16'hFFFF, 1);
		send_word(OP_ENCODE, 16'h3CA5, 0);
		cw = codeword_for(8'hA5);
		send_word(OP_DECODE, cw, 0);
		send_word(OP_DECODE, cw ^ 16'h8000, 0);
		send_word(OP_DECODE, cw ^ 16'h0001, 2);
		send_word(OP_DECODE, cw ^ 16'h0100, 0);
		send_word(OP_DECODE, cw ^ 16'hC000, 0);
		send_word(OP_DECODE, 16'h0000, 0);
		send_word(OP_DECODE, 16'hFFFF, HOLD_DRAIN);

		// all columns equal: first column wins
		for (int i = 0; i < NUM_ROWS; i++)
			h_set[i] = '1;
		write_h();
		send_word(OP_DECODE, 16'h0001, 0);
		send_word(OP_DECODE, 16'h0003, 0);
		send_word(OP_ENCODE, 16'h00FF, 0);
		send_word(OP_ENCODE, 16'h0080, HOLD_DRAIN);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0, 3: begin
					pcols = {$urandom, $urandom};
					set_systematic(pcols);
				end
				1: begin
					for (int i = 0; i < NUM_ROWS; i++)
						h_set[i] = '1;
				end
				2: begin
					for (int i = 0; i < NUM_ROWS; i++)
						h_set[i] = REG_W'($urandom);
				end
				4: begin
					for (int i = 0; i < NUM_ROWS; i++)
						h_set[i] = '0;
				end
				default: begin
					// few distinct column values, so ties are common
					for (int j = 0; j < DATA_BITS; j++)
						pcols[DATA_BITS*j +: DATA_BITS] = DATA_BITS'($urandom_range(0, 3));
					set_systematic(pcols);
				end
			endcase
			write_h();
			burst = (p % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				rnd = CODE_BITS'($urandom);
				cw = codeword_for(rnd[DATA_BITS-1:0]);
				a = $urandom_range(0, CODE_BITS - 1);
				b = (a + $urandom_range(1, CODE_BITS - 1)) % CODE_BITS;
				g = $urandom_range(0, 99);
				if (n == PHASE_ITEMS - 1)
					hold = HOLD_DRAIN;
				else if (burst || g < 60)
					hold = 0;
				else if (g < 90)
					hold = $urandom_range(1, 3);
				else if (g < 99)
					hold = $urandom_range(10, 40);
				else
					hold = HOLD_DRAIN;
				if (r < 30)
					send_word(OP_ENCODE, rnd, hold);
				else if (r < 55)
					send_word(OP_DECODE, cw, hold);
				else if (r < 80)
					send_word(OP_DECODE, cw ^ (CODE_BITS'(1) << a), hold);
				else if (r < 90)
					send_word(OP_DECODE, cw ^ (CODE_BITS'(1) << a) ^ (CODE_BITS'(1) << b), hold);
				else
					send_word(OP_DECODE, rnd, hold);
			end
		end

		// let any stray result show up
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && words_in_flight == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: block_code_encode_correct.f
hw/rtl/bcec_pkg.sv
hw/rtl/bcec_cfg_regs.sv
hw/rtl/bcec_syndrome.sv
hw/rtl/bcec_match.sv
hw/rtl/bcec_correct.sv
hw/rtl/block_code_encode_correct.sv
tb/codeword_checker.sv
tb/testbench.sv
